// ----- design/rtch_pkg.sv -----
// shared types, constants and helper functions of the ray/triangle hit unit
// no dependencies; imported by rtch_ctrl, rtch_dp and the top level
`default_nettype none
package rtch_pkg;

   localparam int unsigned COORD_W  = 32;
   localparam int unsigned WIDE_W   = 50;
   localparam int unsigned DIST_W   = 31;
   localparam int unsigned BARY_W   = 17;
   localparam int unsigned INDEX_W  = 16;
   localparam int unsigned EPS_W    = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned STEP_W   = 5;
   localparam int unsigned QUO_W    = 31;

   localparam logic [DIST_W-1:0] T_MAX = {DIST_W{1'b1}};

   // micro-op table layout: intersection products, then hit point products
   localparam logic [STEP_W-1:0] TRI_OP_LAST = STEP_W'(23);
   localparam logic [STEP_W-1:0] HIT_OP_FIRST = STEP_W'(24);
   localparam logic [STEP_W-1:0] HIT_OP_LAST = STEP_W'(26);
   localparam logic [STEP_W-1:0] DIV_STEP_LAST = STEP_W'(QUO_W - 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORG_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPS   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd7;

   // operand vectors of the shared multiplier
   typedef enum logic [2:0] {
      VEC_DIR = 3'd0,
      VEC_E1  = 3'd1,
      VEC_E2  = 3'd2,
      VEC_TV  = 3'd3,
      VEC_PV  = 3'd4,
      VEC_QV  = 3'd5,
      VEC_T   = 3'd6
   } vec_type;

   // where a finished sum goes
   typedef enum logic [3:0] {
      DST_NONE = 4'd0,
      DST_PV0  = 4'd1,
      DST_PV1  = 4'd2,
      DST_PV2  = 4'd3,
      DST_QV0  = 4'd4,
      DST_QV1  = 4'd5,
      DST_QV2  = 4'd6,
      DST_DET  = 4'd7,
      DST_UN   = 4'd8,
      DST_VN   = 4'd9,
      DST_TN   = 4'd10,
      DST_HX   = 4'd11,
      DST_HY   = 4'd12,
      DST_HZ   = 4'd13
   } dst_type;

   typedef enum logic [1:0] {
      DIV_U = 2'd0,
      DIV_V = 2'd1,
      DIV_T = 2'd2
   } div_sel_type;

   typedef struct packed {
      vec_type     a_vec;
      logic [1:0]  a_comp;
      vec_type     b_vec;
      logic [1:0]  b_comp;
      logic        sub;
      logic        first;
      dst_type     dst;
   } mop_type;

   typedef struct packed {
      logic        load;
      logic        mul;
      logic        acc;
      mop_type     op;
      logic        norm;
      logic        div_init;
      logic        div_step;
      logic        div_last;
      div_sel_type div_sel;
      logic        update;
      logic        count_inc;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic consider;
      logic pass;
      logic found;
      logic last;
      logic rsp_busy;
   } status_type;

   function automatic mop_type mk_op(vec_type av, logic [1:0] ac, vec_type bv,
                                     logic [1:0] bc, logic sub, logic first,
                                     dst_type dst);
      mop_type m;
      m.a_vec  = av;
      m.a_comp = ac;
      m.b_vec  = bv;
      m.b_comp = bc;
      m.sub    = sub;
      m.first  = first;
      m.dst    = dst;
      return m;
   endfunction

   // product sequence: pv = dir x e2, det, un, qv = tv x e1, vn, tn, hit point
   function automatic mop_type op_table(logic [STEP_W-1:0] step);
      mop_type m;
      m = mk_op(VEC_DIR, 2'd0, VEC_E2, 2'd0, 1'b0, 1'b1, DST_NONE);
      unique case (step)
         5'd0:  m = mk_op(VEC_DIR, 2'd1, VEC_E2, 2'd2, 1'b0, 1'b1, DST_NONE);
         5'd1:  m = mk_op(VEC_DIR, 2'd2, VEC_E2, 2'd1, 1'b1, 1'b0, DST_PV0);
         5'd2:  m = mk_op(VEC_DIR, 2'd2, VEC_E2, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd3:  m = mk_op(VEC_DIR, 2'd0, VEC_E2, 2'd2, 1'b1, 1'b0, DST_PV1);
         5'd4:  m = mk_op(VEC_DIR, 2'd0, VEC_E2, 2'd1, 1'b0, 1'b1, DST_NONE);
         5'd5:  m = mk_op(VEC_DIR, 2'd1, VEC_E2, 2'd0, 1'b1, 1'b0, DST_PV2);
         5'd6:  m = mk_op(VEC_E1, 2'd0, VEC_PV, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd7:  m = mk_op(VEC_E1, 2'd1, VEC_PV, 2'd1, 1'b0, 1'b0, DST_NONE);
         5'd8:  m = mk_op(VEC_E1, 2'd2, VEC_PV, 2'd2, 1'b0, 1'b0, DST_DET);
         5'd9:  m = mk_op(VEC_TV, 2'd0, VEC_PV, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd10: m = mk_op(VEC_TV, 2'd1, VEC_PV, 2'd1, 1'b0, 1'b0, DST_NONE);
         5'd11: m = mk_op(VEC_TV, 2'd2, VEC_PV, 2'd2, 1'b0, 1'b0, DST_UN);
         5'd12: m = mk_op(VEC_TV, 2'd1, VEC_E1, 2'd2, 1'b0, 1'b1, DST_NONE);
         5'd13: m = mk_op(VEC_TV, 2'd2, VEC_E1, 2'd1, 1'b1, 1'b0, DST_QV0);
         5'd14: m = mk_op(VEC_TV, 2'd2, VEC_E1, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd15: m = mk_op(VEC_TV, 2'd0, VEC_E1, 2'd2, 1'b1, 1'b0, DST_QV1);
         5'd16: m = mk_op(VEC_TV, 2'd0, VEC_E1, 2'd1, 1'b0, 1'b1, DST_NONE);
         5'd17: m = mk_op(VEC_TV, 2'd1, VEC_E1, 2'd0, 1'b1, 1'b0, DST_QV2);
         5'd18: m = mk_op(VEC_DIR, 2'd0, VEC_QV, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd19: m = mk_op(VEC_DIR, 2'd1, VEC_QV, 2'd1, 1'b0, 1'b0, DST_NONE);
         5'd20: m = mk_op(VEC_DIR, 2'd2, VEC_QV, 2'd2, 1'b0, 1'b0, DST_VN);
         5'd21: m = mk_op(VEC_E2, 2'd0, VEC_QV, 2'd0, 1'b0, 1'b1, DST_NONE);
         5'd22: m = mk_op(VEC_E2, 2'd1, VEC_QV, 2'd1, 1'b0, 1'b0, DST_NONE);
         5'd23: m = mk_op(VEC_E2, 2'd2, VEC_QV, 2'd2, 1'b0, 1'b0, DST_TN);
         5'd24: m = mk_op(VEC_DIR, 2'd0, VEC_T, 2'd0, 1'b0, 1'b1, DST_HX);
         5'd25: m = mk_op(VEC_DIR, 2'd1, VEC_T, 2'd0, 1'b0, 1'b1, DST_HY);
         5'd26: m = mk_op(VEC_DIR, 2'd2, VEC_T, 2'd0, 1'b0, 1'b1, DST_HZ);
         default: m = mk_op(VEC_DIR, 2'd0, VEC_E2, 2'd0, 1'b0, 1'b1, DST_NONE);
      endcase
      return m;
   endfunction

   // clamp a wide signed sum to signed 32 bits
   function automatic logic signed [COORD_W-1:0] sat32(logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(64'sh7FFFFFFF);
      lo = -WIDE_W'(64'sh80000000);
      if (x > hi) begin
         return 32'sh7FFFFFFF;
      end else if (x < lo) begin
         return 32'sh80000000;
      end
      return x[COORD_W-1:0];
   endfunction

   // saturating difference of two signed 32-bit values
   function automatic logic signed [COORD_W-1:0] sub_sat(logic signed [COORD_W-1:0] a,
                                                        logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[COORD_W] != d[COORD_W-1]) begin
         return d[COORD_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end
      return d[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/rtch_ctrl.sv -----
// controller of the ray/triangle hit unit: sequences products, division and result
// depends on rtch_pkg; drives the datapath rtch_dp through cmd_type
`default_nettype none
module rtch_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire rtch_pkg::status_type status,
   output rtch_pkg::cmd_type         cmd
);
   import rtch_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_MUL   = 10'b00_0000_0010,
      ST_ACC   = 10'b00_0000_0100,
      ST_NORM  = 10'b00_0000_1000,
      ST_CHECK = 10'b00_0001_0000,
      ST_DIVI  = 10'b00_0010_0000,
      ST_DIVS  = 10'b00_0100_0000,
      ST_UPD   = 10'b00_1000_0000,
      ST_WRAP  = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [STEP_W-1:0] dcnt_ff, dcnt_in;
   div_sel_type     dsel_ff, dsel_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dcnt_in  = dcnt_ff;
      dsel_in  = dsel_ff;
      cmd      = '0;
      cmd.op   = op_table(step_ff);
      cmd.div_sel = dsel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = status.consider ? ST_MUL : ST_WRAP;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (step_ff == TRI_OP_LAST) begin
               state_in = ST_NORM;
            end else if (step_ff == HIT_OP_LAST) begin
               state_in = ST_EMIT;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            dsel_in  = DIV_U;
            state_in = status.pass ? ST_DIVI : ST_WRAP;
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + STEP_W'(1);
            if (dcnt_ff == DIV_STEP_LAST) begin
               cmd.div_last = 1'b1;
               unique case (dsel_ff)
                  DIV_U: begin
                     dsel_in  = DIV_V;
                     state_in = ST_DIVI;
                  end
                  DIV_V: begin
                     dsel_in  = DIV_T;
                     state_in = ST_DIVI;
                  end
                  default: begin
                     state_in = ST_UPD;
                  end
               endcase
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_WRAP;
         end
         ST_WRAP: begin
            cmd.count_inc = 1'b1;
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.found) begin
               step_in  = HIT_OP_FIRST;
               state_in = ST_MUL;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         dcnt_ff  <= '0;
         dsel_ff  <= DIV_U;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         dcnt_ff  <= dcnt_in;
         dsel_ff  <= dsel_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/rtch_dp.sv -----
// datapath of the ray/triangle hit unit: ray registers, shared multiplier,
// serial divider, nearest-hit state and result register; depends on rtch_pkg
`default_nettype none
module rtch_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rtch_pkg::cmd_type                   cmd,
   output rtch_pkg::status_type                     status,
   input  wire logic                                csr_valid,
   input  wire logic [rtch_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rtch_pkg::COORD_W-1:0]        csr_data,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_z,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_z,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_z,
   input  wire logic                                req_last_triangle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [rtch_pkg::DIST_W-1:0]              rsp_distance,
   output logic [rtch_pkg::BARY_W-1:0]              rsp_u_coord,
   output logic [rtch_pkg::BARY_W-1:0]              rsp_v_coord,
   output logic [rtch_pkg::INDEX_W-1:0]             rsp_tri_index,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_x,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_y,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_z
);
   import rtch_pkg::*;

   // configuration
   logic signed [COORD_W-1:0] org_ff [3];
   logic signed [COORD_W-1:0] dir_ff [3];
   logic [EPS_W-1:0]          eps_ff;
   logic                      mode_ff;

   // per-triangle operands
   logic signed [COORD_W-1:0] e1_ff [3];
   logic signed [COORD_W-1:0] e2_ff [3];
   logic signed [COORD_W-1:0] tv_ff [3];
   logic signed [COORD_W-1:0] pv_ff [3];
   logic signed [COORD_W-1:0] qv_ff [3];
   logic signed [COORD_W-1:0] hp_ff [3];
   logic                      last_ff;

   logic signed [2*COORD_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0]    acc_ff;
   logic signed [WIDE_W-1:0]    det_ff, un_ff, vn_ff, tn_ff;

   // divider
   logic [WIDE_W:0]   rem_ff;
   logic [QUO_W-1:0]  sh_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic              ovf_ff;
   logic [BARY_W-1:0] u_ff, v_ff;
   logic [DIST_W-1:0] t_ff;

   // search state
   logic [DIST_W-1:0]  nearest_ff;
   logic [BARY_W-1:0]  best_u_ff, best_v_ff;
   logic [INDEX_W-1:0] best_idx_ff, count_ff;
   logic               found_ff;

   // result register
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic [BARY_W-1:0]  rsp_u_ff, rsp_v_ff;
   logic [INDEX_W-1:0] rsp_idx_ff;
   logic signed [COORD_W-1:0] rsp_hx_ff, rsp_hy_ff, rsp_hz_ff;

   function automatic logic signed [COORD_W-1:0] pick(
      vec_type vsel, logic [1:0] c,
      logic signed [COORD_W-1:0] d0, logic signed [COORD_W-1:0] d1,
      logic signed [COORD_W-1:0] d2);
      logic signed [COORD_W-1:0] r;
      unique case (c)
         2'd0:    r = d0;
         2'd1:    r = d1;
         default: r = d2;
      endcase
      return (vsel == VEC_T) ? d0 : r;
   endfunction

   logic signed [COORD_W-1:0] opa, opb;
   logic signed [COORD_W-1:0] t_oper;

   assign t_oper = {1'b0, nearest_ff};

   // operand selection
   always_comb begin
      unique case (cmd.op.a_vec)
         VEC_E1:  opa = pick(VEC_E1, cmd.op.a_comp, e1_ff[0], e1_ff[1], e1_ff[2]);
         VEC_E2:  opa = pick(VEC_E2, cmd.op.a_comp, e2_ff[0], e2_ff[1], e2_ff[2]);
         VEC_TV:  opa = pick(VEC_TV, cmd.op.a_comp, tv_ff[0], tv_ff[1], tv_ff[2]);
         default: opa = pick(VEC_DIR, cmd.op.a_comp, dir_ff[0], dir_ff[1], dir_ff[2]);
      endcase
      unique case (cmd.op.b_vec)
         VEC_E1:  opb = pick(VEC_E1, cmd.op.b_comp, e1_ff[0], e1_ff[1], e1_ff[2]);
         VEC_PV:  opb = pick(VEC_PV, cmd.op.b_comp, pv_ff[0], pv_ff[1], pv_ff[2]);
         VEC_QV:  opb = pick(VEC_QV, cmd.op.b_comp, qv_ff[0], qv_ff[1], qv_ff[2]);
         VEC_T:   opb = pick(VEC_T, cmd.op.b_comp, t_oper, t_oper, t_oper);
         default: opb = pick(VEC_E2, cmd.op.b_comp, e2_ff[0], e2_ff[1], e2_ff[2]);
      endcase
   end

   // accumulate the floored product
   logic signed [WIDE_W-1:0] p_ext, acc_base, acc_sum;
   logic signed [COORD_W-1:0] acc_sat, hit_sat;
   logic [1:0] hcomp;

   always_comb begin
      p_ext    = WIDE_W'(prod_ff >>> 16);
      acc_base = cmd.op.first ? '0 : acc_ff;
      acc_sum  = cmd.op.sub ? (acc_base - p_ext) : (acc_base + p_ext);
      acc_sat  = sat32(acc_sum);
      hcomp    = cmd.op.a_comp;
      unique case (hcomp)
         2'd0:    hit_sat = sat32(WIDE_W'(org_ff[0]) + acc_sum);
         2'd1:    hit_sat = sat32(WIDE_W'(org_ff[1]) + acc_sum);
         default: hit_sat = sat32(WIDE_W'(org_ff[2]) + acc_sum);
      endcase
   end

   // divider source and step
   logic signed [WIDE_W-1:0] dvd;
   logic [WIDE_W:0]  det_u, rem_sh, rem_nx;
   logic             qbit;
   logic [QUO_W-1:0] quo_nx;

   always_comb begin
      unique case (cmd.div_sel)
         DIV_U:   dvd = un_ff;
         DIV_V:   dvd = vn_ff;
         default: dvd = tn_ff;
      endcase
      det_u  = {1'b0, det_ff};
      rem_sh = {rem_ff[WIDE_W-1:0], sh_ff[QUO_W-1]};
      qbit   = (rem_sh >= det_u);
      rem_nx = qbit ? (rem_sh - det_u) : rem_sh;
      quo_nx = {quo_ff[QUO_W-2:0], qbit};
   end

   // acceptance test on the normalized sums
   logic signed [WIDE_W:0] uv_sum;
   logic [DIST_W-1:0]      t_final;

   always_comb begin
      uv_sum = {un_ff[WIDE_W-1], un_ff} + {vn_ff[WIDE_W-1], vn_ff};
      status.pass = (det_ff != '0) && (det_ff >= WIDE_W'($signed({1'b0, eps_ff}))) &&
                    !un_ff[WIDE_W-1] && (un_ff <= det_ff) && !vn_ff[WIDE_W-1] &&
                    (uv_sum <= {det_ff[WIDE_W-1], det_ff}) &&
                    !tn_ff[WIDE_W-1] && (tn_ff != '0);
      status.consider = !(mode_ff && found_ff);
      status.found    = found_ff;
      status.last     = last_ff;
      status.rsp_busy = rsp_valid_ff;
      t_final = t_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= '0;
            dir_ff[k] <= '0;
         end
         dir_ff[2] <= 32'sh0001_0000;
         eps_ff    <= EPS_W'(1);
         mode_ff   <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ORG_X: org_ff[0] <= csr_data;
            CSR_ORG_Y: org_ff[1] <= csr_data;
            CSR_ORG_Z: org_ff[2] <= csr_data;
            CSR_DIR_X: dir_ff[0] <= csr_data;
            CSR_DIR_Y: dir_ff[1] <= csr_data;
            CSR_DIR_Z: dir_ff[2] <= csr_data;
            CSR_EPS:   eps_ff    <= csr_data[EPS_W-1:0];
            default:   mode_ff   <= csr_data[0];
         endcase
      end
   end

   // operand loading, products, sums and division
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e1_ff[0] <= sub_sat(req_v1_x, req_v0_x);
         e1_ff[1] <= sub_sat(req_v1_y, req_v0_y);
         e1_ff[2] <= sub_sat(req_v1_z, req_v0_z);
         e2_ff[0] <= sub_sat(req_v2_x, req_v0_x);
         e2_ff[1] <= sub_sat(req_v2_y, req_v0_y);
         e2_ff[2] <= sub_sat(req_v2_z, req_v0_z);
         tv_ff[0] <= sub_sat(org_ff[0], req_v0_x);
         tv_ff[1] <= sub_sat(org_ff[1], req_v0_y);
         tv_ff[2] <= sub_sat(org_ff[2], req_v0_z);
         last_ff  <= req_last_triangle;
      end
      if (cmd.mul) begin
         prod_ff <= opa * opb;
      end
      if (cmd.acc) begin
         acc_ff <= acc_sum;
         unique case (cmd.op.dst)
            DST_PV0: pv_ff[0] <= acc_sat;
            DST_PV1: pv_ff[1] <= acc_sat;
            DST_PV2: pv_ff[2] <= acc_sat;
            DST_QV0: qv_ff[0] <= acc_sat;
            DST_QV1: qv_ff[1] <= acc_sat;
            DST_QV2: qv_ff[2] <= acc_sat;
            DST_DET: det_ff   <= acc_sum;
            DST_UN:  un_ff    <= acc_sum;
            DST_VN:  vn_ff    <= acc_sum;
            DST_TN:  tn_ff    <= acc_sum;
            DST_HX:  hp_ff[0] <= hit_sat;
            DST_HY:  hp_ff[1] <= hit_sat;
            DST_HZ:  hp_ff[2] <= hit_sat;
            default: ;
         endcase
      end
      // make the determinant positive
      if (cmd.norm && det_ff[WIDE_W-1]) begin
         det_ff <= -det_ff;
         un_ff  <= -un_ff;
         vn_ff  <= -vn_ff;
         tn_ff  <= -tn_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= {16'b0, dvd[WIDE_W-1:15]};
         sh_ff  <= {dvd[14:0], 16'b0};
         quo_ff <= '0;
         ovf_ff <= ({16'b0, dvd[WIDE_W-1:15]} >= det_u);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_nx;
         sh_ff  <= {sh_ff[QUO_W-2:0], 1'b0};
         quo_ff <= quo_nx;
      end
      if (cmd.div_last) begin
         unique case (cmd.div_sel)
            DIV_U:   u_ff <= quo_nx[BARY_W-1:0];
            DIV_V:   v_ff <= quo_nx[BARY_W-1:0];
            default: t_ff <= ovf_ff ? T_MAX : quo_nx;
         endcase
      end
   end

   // nearest-hit search state
   always_ff @(posedge clock) begin
      if (reset) begin
         nearest_ff  <= T_MAX;
         best_u_ff   <= '0;
         best_v_ff   <= '0;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
         count_ff    <= '0;
      end else if (cmd.emit) begin
         nearest_ff  <= T_MAX;
         best_u_ff   <= '0;
         best_v_ff   <= '0;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (cmd.update && (t_final != '0) && (t_final < nearest_ff)) begin
            nearest_ff  <= t_final;
            best_u_ff   <= u_ff;
            best_v_ff   <= v_ff;
            best_idx_ff <= count_ff;
            found_ff    <= 1'b1;
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + INDEX_W'(1);
         end
      end
   end

   // result register: held until the receiver takes the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_hit_ff  <= found_ff;
         rsp_dist_ff <= found_ff ? nearest_ff : T_MAX;
         rsp_u_ff    <= found_ff ? best_u_ff : '0;
         rsp_v_ff    <= found_ff ? best_v_ff : '0;
         rsp_idx_ff  <= found_ff ? best_idx_ff : '0;
         rsp_hx_ff   <= found_ff ? hp_ff[0] : '0;
         rsp_hy_ff   <= found_ff ? hp_ff[1] : '0;
         rsp_hz_ff   <= found_ff ? hp_ff[2] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_u_coord   = rsp_u_ff;
   assign rsp_v_coord   = rsp_v_ff;
   assign rsp_tri_index = rsp_idx_ff;
   assign rsp_hit_x     = rsp_hx_ff;
   assign rsp_hit_y     = rsp_hy_ff;
   assign rsp_hit_z     = rsp_hz_ff;

endmodule
`default_nettype wire

// ----- design/ray_triangle_closest_hit_unit.sv -----
// Ray/triangle closest-hit unit. One ray sits in the csr_ registers (origin,
// direction, parallel epsilon, any-hit mode); triangles stream in on req_ as
// three Q16.16 vertices. A req_ transfer takes place when req_valid is high and
// req_stall low; the block stalls while it works on a triangle, one at a time.
// A triangle that is not skipped in any-hit mode takes 24 products on one
// shared 32x32 multiplier; if it passes the determinant, barycentric and
// distance tests, three 31-step restoring divisions of u, v and t follow.
// On the triangle flagged last_triangle one result follows on rsp_: when a hit
// was found the hit point is computed first, then the result register is loaded.
// The result register holds rsp_ payload while rsp_stall is high; a new
// result waits in its state until the previous transfer has gone.
// csr_ready is always high; write registers only while the block is idle.
// Synchronous reset restores the ray registers to their defaults (direction
// +z, epsilon one unit, nearest-hit mode) and clears the search state.
// depends on rtch_pkg, rtch_ctrl and rtch_dp
`default_nettype none
module ray_triangle_closest_hit_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rtch_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rtch_pkg::COORD_W-1:0]        csr_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v0_z,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v1_z,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_x,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_y,
   input  wire logic signed [rtch_pkg::COORD_W-1:0] req_v2_z,
   input  wire logic                                req_last_triangle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic [rtch_pkg::DIST_W-1:0]              rsp_distance,
   output logic [rtch_pkg::BARY_W-1:0]              rsp_u_coord,
   output logic [rtch_pkg::BARY_W-1:0]              rsp_v_coord,
   output logic [rtch_pkg::INDEX_W-1:0]             rsp_tri_index,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_x,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_y,
   output logic signed [rtch_pkg::COORD_W-1:0]      rsp_hit_z
);
   import rtch_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   rtch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   rtch_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_v0_x          (req_v0_x),
      .req_v0_y          (req_v0_y),
      .req_v0_z          (req_v0_z),
      .req_v1_x          (req_v1_x),
      .req_v1_y          (req_v1_y),
      .req_v1_z          (req_v1_z),
      .req_v2_x          (req_v2_x),
      .req_v2_y          (req_v2_y),
      .req_v2_z          (req_v2_z),
      .req_last_triangle (req_last_triangle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_distance      (rsp_distance),
      .rsp_u_coord       (rsp_u_coord),
      .rsp_v_coord       (rsp_v_coord),
      .rsp_tri_index     (rsp_tri_index),
      .rsp_hit_x         (rsp_hit_x),
      .rsp_hit_y         (rsp_hit_y),
      .rsp_hit_z         (rsp_hit_z)
   );

endmodule
`default_nettype wire
